// File: src/srrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_pkg
// Types, widths and codes shared by the selective-repeat receiver window.
// ----------------------------------------------------------------------------
package srrw_pkg;

	localparam int DEF_MAX_WINDOW  = 16;
	localparam int DEF_MAX_PAYLOAD = 1024;

	localparam int SEQ_W      = 32;
	localparam int TAG_W      = 16;
	localparam int LEN_W      = 11;
	localparam int WLIM_W     = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_BYTES = 1'd1;

	localparam logic [WLIM_W-1:0] WLIM_RESET = 5'd8;

	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	typedef struct packed {
		logic [SEQ_W-1:0] seq_number;
		logic [TAG_W-1:0] payload_tag;
		logic [LEN_W-1:0] payload_length;
	} packet_word_t;

	typedef struct packed {
		logic             kind;
		logic [SEQ_W-1:0] out_seq;
		logic [TAG_W-1:0] out_tag;
		logic [LEN_W-1:0] out_length;
		logic             last;
		logic             done_res;
	} result_word_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] len;
	} slot_entry_t;

endpackage

// File: src/srrw_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_chan_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface srrw_chan_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/srrw_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_slot_mem
// Slot store for buffered tag/length, one write and one registered read per
// cycle; a write to the address being read is forwarded to the read data.
// ----------------------------------------------------------------------------
module srrw_slot_mem
	import srrw_pkg::*;
#(
	parameter int DEPTH  = DEF_MAX_WINDOW,
	parameter int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_addr,
	input  slot_entry_t       wr_data,
	input  logic [SLOT_W-1:0] rd_addr,
	output slot_entry_t       rd_data
);

	slot_entry_t mem [DEPTH];
	slot_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: src/sr_receiver_reorder_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sr_receiver_reorder_window
// Selective-repeat receiver: buffers out-of-order packets, delivers the
// contiguous run at the window base in order, acks in-window and recent ones.
// ----------------------------------------------------------------------------
// A packet releasing n entries (1..MAX_WINDOW) is walked with one slot memory
//   read per entry, then a stop and an ack; an ack-only packet only acks. No new
//   packet is taken until the ack is issued, and result stalls hold the walk and
//   the ack. Dropped or ignored packets give no word.
// Reset: base, slot valid flags, byte counter and done flag clear at once;
//   window limit returns to 8; slot memory is not cleared.
module sr_receiver_reorder_window
	import srrw_pkg::*;
#(
	parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
	parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	srrw_chan_if.sink             packet,
	srrw_chan_if.source           result
);

	localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_ACK  = 2'd2;

	logic [1:0]            state_q;
	logic [SEQ_W-1:0]      base_q;
	logic [SLOT_W-1:0]     base_slot_q;
	logic [MAX_WINDOW-1:0] slot_valid_q;
	logic [SEQ_W-1:0]      bytes_q;
	logic                  finished_q;
	logic [WLIM_W-1:0]     wlim_q;
	logic [WIN_W-1:0]      walked_q;
	logic [SEQ_W-1:0]      seq_q;
	result_word_t          out_q;
	logic                  out_valid_q;

	packet_word_t          pkt;
	logic                  accept;
	logic                  out_free;
	logic [WIN_W-1:0]      w_eff;
	logic [SEQ_W-1:0]      ahead;
	logic [SEQ_W-1:0]      behind;
	logic                  in_win;
	logic                  behind_ok;
	logic [SLOT_W:0]       slot_sum;
	logic [SLOT_W:0]       slot_red;
	logic [SLOT_W-1:0]     seq_slot;
	logic                  buf_wr;
	logic [LEN_W-1:0]      len_sat;
	slot_entry_t           wr_entry;
	slot_entry_t           rd_entry;
	logic [SLOT_W-1:0]     rd_addr;
	logic [SLOT_W-1:0]     base_slot_nxt;
	logic                  walk_stop;
	logic                  walk_emit;
	logic                  ack_emit;
	logic [SEQ_W-1:0]      bytes_nxt;

	assign pkt          = packet.data;
	assign packet.ready = (state_q == ST_IDLE);
	assign accept       = packet.valid && packet.ready;
	assign out_free     = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	always_comb begin
		if (wlim_q == '0) begin
			w_eff = WIN_W'(1);
		end else if (32'(wlim_q) > 32'(MAX_WINDOW)) begin
			w_eff = WIN_W'(MAX_WINDOW);
		end else begin
			w_eff = WIN_W'(wlim_q);
		end
	end

	assign ahead     = pkt.seq_number - base_q;
	assign behind    = base_q - pkt.seq_number;
	assign in_win    = ahead < SEQ_W'(w_eff);
	assign behind_ok = (behind != '0) && (behind <= SEQ_W'(w_eff));

	// slot = seq mod MAX_WINDOW, from the base slot; a wrapped seq is small
	assign slot_sum = (SLOT_W + 1)'(base_slot_q) + ahead[SLOT_W:0];
	assign slot_red = (slot_sum >= (SLOT_W + 1)'(MAX_WINDOW)) ?
		slot_sum - (SLOT_W + 1)'(MAX_WINDOW) : slot_sum;
	assign seq_slot = (pkt.seq_number < base_q) ?
		pkt.seq_number[SLOT_W-1:0] : slot_red[SLOT_W-1:0];

	assign len_sat = (32'(pkt.payload_length) > 32'(MAX_PAYLOAD)) ?
		LEN_W'(MAX_PAYLOAD) : pkt.payload_length;
	assign wr_entry = '{tag: pkt.payload_tag, len: len_sat};
	assign buf_wr   = accept && !finished_q && in_win && !slot_valid_q[seq_slot];

	assign base_slot_nxt = (base_q == '1) ? '0 :
		(base_slot_q == SLOT_W'(MAX_WINDOW - 1)) ? '0 : base_slot_q + 1'b1;

	assign walk_stop = !slot_valid_q[base_slot_q] || (walked_q == WIN_W'(MAX_WINDOW));
	assign walk_emit = (state_q == ST_WALK) && !walk_stop && out_free;
	assign ack_emit  = (state_q == ST_ACK) && out_free;
	assign rd_addr   = walk_emit ? base_slot_nxt : base_slot_q;

	assign bytes_nxt = (bytes_q > SEQ_W'(rd_entry.len)) ?
		bytes_q - SEQ_W'(rd_entry.len) : '0;

	srrw_slot_mem #(
		.DEPTH  (MAX_WINDOW),
		.SLOT_W (SLOT_W)
	) u_slot_mem (
		.clk     (clk),
		.wr_en   (buf_wr),
		.wr_addr (seq_slot),
		.wr_data (wr_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			base_q       <= '0;
			base_slot_q  <= '0;
			slot_valid_q <= '0;
			bytes_q      <= '0;
			finished_q   <= 1'b0;
			wlim_q       <= WLIM_RESET;
			walked_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (buf_wr) begin
				slot_valid_q[seq_slot] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !finished_q) begin
						if (in_win) begin
							if (!slot_valid_q[seq_slot] && (ahead == '0)) begin
								state_q  <= ST_WALK;
								walked_q <= '0;
							end else begin
								state_q <= ST_ACK;
							end
						end else if (behind_ok) begin
							state_q <= ST_ACK;
						end
					end
				end
				ST_WALK: begin
					if (walk_stop) begin
						state_q <= ST_ACK;
					end else if (walk_emit) begin
						slot_valid_q[base_slot_q] <= 1'b0;
						base_q      <= base_q + 1'b1;
						base_slot_q <= base_slot_nxt;
						walked_q    <= walked_q + 1'b1;
						bytes_q     <= bytes_nxt;
						if (bytes_nxt == '0) begin
							finished_q <= 1'b1;
						end
					end
				end
				ST_ACK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (walk_emit || ack_emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_WINDOW_LIMIT:   wlim_q  <= cfg_data[WLIM_W-1:0];
					REG_EXPECTED_BYTES: bytes_q <= cfg_data[SEQ_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q <= pkt.seq_number;
		end
		if (walk_emit) begin
			out_q <= '{kind: KIND_DELIVER, out_seq: base_q, out_tag: rd_entry.tag,
				out_length: rd_entry.len, last: 1'b0,
				done_res: finished_q || (bytes_nxt == '0)};
		end else if (ack_emit) begin
			out_q <= '{kind: KIND_ACK, out_seq: seq_q, out_tag: '0,
				out_length: '0, last: 1'b1, done_res: finished_q};
		end
	end

`ifndef NO_ASSERTIONS
	a_deliver_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.kind == KIND_DELIVER)) |-> !out_q.last)
		else $error("deliver word marked last");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("done flag cleared without reset");

	a_walk_clears_slot: assert property (@(posedge clk) disable iff (!arst_n)
		walk_emit |=> !slot_valid_q[$past(base_slot_q)])
		else $error("delivered slot still valid");

	a_bytes_no_rise: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr_en |=> (bytes_q <= $past(bytes_q)))
		else $error("byte counter rose without a write");
`endif

endmodule
